// ===== hw/rtl/bve_pkg.sv =====
// ----------------------------------------------------------------------------
// bve_pkg
// Operation and status codes plus the per-cell control group of the vector
// engine.
// ----------------------------------------------------------------------------
package bve_pkg;

    typedef enum logic [2:0] {
        FN_PUSH   = 3'd0,
        FN_POP    = 3'd1,
        FN_GET    = 3'd2,
        FN_SET    = 3'd3,
        FN_INSERT = 3'd4,
        FN_RESIZE = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LIMIT  = 2'd1,
        ST_BADPOS = 2'd2
    } status_t;

    // broadcast to every cell in the accepting cycle
    typedef struct packed {
        logic wr;   // write the word into the target cell
        logic ins;  // write the target cell, cells above it take their lower neighbor
    } cell_ctl_t;

endpackage

// ===== hw/rtl/bounded_vector_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_vector_engine
// Fixed-capacity word vector with push, pop, get, set, insert and resize.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. Each item
// gives one result on status, word_out and count_out, shown for exactly one
// cycle while done is high; the receiver cannot hold it off.
// The store is a row of CAPACITY cells, one word each. Push, set, insert,
// resize and every error finish in the accepting cycle: done rises in the cycle
// after the accept and busy stays low, so these items run at one per cycle.
// Insert shifts all affected cells at once.
// A successful pop or get sends a read sweep through the row, one cell per
// cycle; busy stays high until the sweep leaves the top cell, done is
// registered from that, and the next item can be taken in the done cycle.
// Reset clears every cell to zero and the count to zero at once, no clearing
// pass. Entries exposed by a growing resize keep their old contents.
// ----------------------------------------------------------------------------
module bounded_vector_engine #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [5:0]  position,
    input  logic [6:0]  new_count,
    input  logic [63:0] word_in,
    output logic        done,
    output logic [1:0]  status,
    output logic [63:0] word_out,
    output logic [6:0]  count_out
);
    import bve_pkg::*;

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

    typedef enum logic {IDLE, SWEEP} state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      tgt_reg, tgt_next;
    logic               launch_reg, launch_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [63:0]        word_reg, word_next;

    logic               accept;
    logic [CMPW-1:0]    cnt_ext;
    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    req_ext;
    cell_ctl_t          ctl;
    logic [IW-1:0]      wr_tgt;

    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic                 chain_v   [CAPACITY+1];
    logic [WORD_BITS-1:0] chain_w   [CAPACITY+1];

    assign accept  = start && (state_reg == IDLE);
    assign cnt_ext = CMPW'(count_reg);
    assign pos_ext = CMPW'(position);
    assign req_ext = CMPW'(new_count);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        tgt_next    = tgt_reg;
        launch_next = 1'b0;
        done_next   = 1'b0;
        status_next = status_reg;
        word_next   = word_reg;
        ctl         = '0;
        wr_tgt      = '0;

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    word_next   = '0;
                    done_next   = 1'b1;
                    case (func)
                        FN_PUSH:
                        begin
                            if (cnt_ext >= CAP_C)
                                status_next = ST_LIMIT;
                            else
                            begin
                                ctl.wr     = 1'b1;
                                wr_tgt     = count_reg[IW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_POP:
                        begin
                            if (count_reg == '0)
                                status_next = ST_LIMIT;
                            else
                            begin
                                count_next  = count_reg - CW'(1);
                                tgt_next    = IW'(count_reg - CW'(1));
                                launch_next = 1'b1;
                                done_next   = 1'b0;
                                state_next  = SWEEP;
                            end
                        end
                        FN_GET:
                        begin
                            if (pos_ext >= cnt_ext)
                                status_next = ST_LIMIT;
                            else
                            begin
                                tgt_next    = pos_ext[IW-1:0];
                                launch_next = 1'b1;
                                done_next   = 1'b0;
                                state_next  = SWEEP;
                            end
                        end
                        FN_SET:
                        begin
                            if (pos_ext >= cnt_ext)
                                status_next = ST_LIMIT;
                            else
                            begin
                                ctl.wr = 1'b1;
                                wr_tgt = pos_ext[IW-1:0];
                            end
                        end
                        FN_INSERT:
                        begin
                            // position check wins over the full check
                            if (pos_ext >= cnt_ext)
                                status_next = ST_BADPOS;
                            else if (cnt_ext >= CAP_C)
                                status_next = ST_LIMIT;
                            else
                            begin
                                ctl.ins    = 1'b1;
                                wr_tgt     = pos_ext[IW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_RESIZE:
                        begin
                            if (req_ext > CAP_C)
                                status_next = ST_LIMIT;
                            else
                                count_next = req_ext[CW-1:0];
                        end
                        default:
                        begin
                            status_next = ST_BADPOS;
                        end
                    endcase
                end
            end
            SWEEP:
            begin
                if (chain_v[CAPACITY])
                begin
                    word_next  = 64'(chain_w[CAPACITY]);
                    done_next  = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            count_reg  <= '0;
            tgt_reg    <= '0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            word_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            tgt_reg    <= tgt_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            word_reg   <= word_next;
        end
    end

    // read sweep enters at cell 0 and leaves past the top cell
    assign chain_v[0] = launch_reg;
    assign chain_w[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left;
        if (i == 0)
        begin : g_bottom
            assign left = '0;
        end
        else
        begin : g_upper
            assign left = cell_word[i-1];
        end

        bve_cell #(
            .INDEX     (i),
            .IDX_BITS  (IW),
            .CNT_BITS  (CW),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .wr_tgt       (wr_tgt),
            .cnt          (count_reg),
            .wr_word      (word_in[WORD_BITS-1:0]),
            .left_word    (left),
            .rd_tgt       (tgt_reg),
            .rd_in_valid  (chain_v[i]),
            .rd_in_word   (chain_w[i]),
            .word         (cell_word[i]),
            .rd_out_valid (chain_v[i+1]),
            .rd_out_word  (chain_w[i+1])
        );
    end

    assign busy      = (state_reg != IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign word_out  = word_reg;
    assign count_out = cnt_ext[6:0];

endmodule

// ===== hw/rtl/bve_cell.sv =====
// ----------------------------------------------------------------------------
// bve_cell
// One entry of the vector. Holds a word, takes its lower neighbor's word on
// insert, and forwards the read sweep one stage per cycle.
// ----------------------------------------------------------------------------
module bve_cell #(
    parameter int INDEX     = 0,
    parameter int IDX_BITS  = 6,
    parameter int CNT_BITS  = 7,
    parameter int WORD_BITS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bve_pkg::cell_ctl_t      ctl,
    input  logic [IDX_BITS-1:0]     wr_tgt,
    input  logic [CNT_BITS-1:0]     cnt,
    input  logic [WORD_BITS-1:0]    wr_word,
    input  logic [WORD_BITS-1:0]    left_word,
    input  logic [IDX_BITS-1:0]     rd_tgt,
    input  logic                    rd_in_valid,
    input  logic [WORD_BITS-1:0]    rd_in_word,
    output logic [WORD_BITS-1:0]    word,
    output logic                    rd_out_valid,
    output logic [WORD_BITS-1:0]    rd_out_word
);
    import bve_pkg::*;

    localparam logic [IDX_BITS-1:0] IDX_I = IDX_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] IDX_C = CNT_BITS'(INDEX);

    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 rdv_reg;
    logic [WORD_BITS-1:0] rdw_reg, rdw_next;
    logic                 is_tgt;
    logic                 above;

    assign is_tgt = (wr_tgt == IDX_I);
    // strictly above the insert point and at or below the old count
    assign above  = (IDX_I > wr_tgt) && (IDX_C <= cnt);

    always_comb
    begin
        word_next = word_reg;
        if ((ctl.wr || ctl.ins) && is_tgt)
        begin
            word_next = wr_word;
        end
        else if (ctl.ins && above)
        begin
            word_next = left_word;
        end
        rdw_next = (rd_in_valid && (rd_tgt == IDX_I)) ? word_reg : rd_in_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            rdv_reg  <= 1'b0;
        end
        else
        begin
            word_reg <= word_next;
            rdv_reg  <= rd_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rdw_reg <= rdw_next;
    end

    assign word         = word_reg;
    assign rd_out_valid = rdv_reg;
    assign rd_out_word  = rdw_reg;

endmodule
